// ===== hw/rtl/rbwa_pkg.sv =====
package rbwa_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int WIN_W               = 8;
   localparam int FRAC_W              = 8;
   localparam int MEAN_W              = 24;
   // window never exceeds 255 samples, so this sum cannot overflow
   localparam int SUM_W               = SAMPLE_W + WIN_W;

   localparam int STORE_DEPTH_DEFAULT = 16;

   localparam int CSR_DATA_W          = 32;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_INDEX_W         = CSR_ADDR_W - 2;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = CSR_INDEX_W'(0);
   localparam logic [WIN_W-1:0]       WINDOW_RESET      = WIN_W'(16);

endpackage

// ===== hw/rtl/rbwa_ram.sv =====
module rbwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/ring_buffer_window_average_core.sv =====
// Channel | Dir | Fields (tdata, low bit up)       | Handshake
// req     | in  | sample[15:0]                     | tvalid/tready
// rsp     | out | mean_q8[23:0]                    | tvalid/tready
// csr     | in  | window_length at byte address 0  | APB, pready always high
//
// One transaction at a time. Per sample, with W the clamped window: an accept,
// W sample reads from the single read port plus the read latency of the store,
// a divider load, 24 restoring divide steps and a load of the output register.
// Reset clears the valid bit of every store entry at once; no clearing sweep.
// A result waiting in the output register does not block the next sample,
// only the load of the following result.
module ring_buffer_window_average_core #(
   parameter int STORE_DEPTH = rbwa_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: sample[15:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rbwa_pkg::SAMPLE_W-1:0]     req_tdata,
   // rsp_tdata: mean_q8[23:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rbwa_pkg::MEAN_W-1:0]       rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbwa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rbwa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rbwa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int PTR_W  = $clog2(STORE_DEPTH);
   localparam int WIN_W  = rbwa_pkg::WIN_W;
   localparam int SUM_W  = rbwa_pkg::SUM_W;
   localparam int MEAN_W = rbwa_pkg::MEAN_W;
   localparam int STEP_W = $clog2(MEAN_W + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(STORE_DEPTH - 1);
   localparam logic [WIN_W-1:0] DEPTH_WIN = WIN_W'(STORE_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DIV, ST_PUSH} state_type;

   state_type                     state_ff, state_in;
   logic [STORE_DEPTH-1:0]        valid_ff, valid_in;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic [WIN_W-1:0]              window_ff, window_in;
   logic [WIN_W-1:0]              win_ff, win_in;
   logic [WIN_W-1:0]              left_ff, left_in;
   logic [PTR_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                          pend_ff, pend_in;
   logic                          vld_d_ff, vld_d_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [WIN_W-1:0]              rem_ff, rem_in;
   logic [MEAN_W-1:0]             dv_ff, dv_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [MEAN_W-1:0]             rsp_tdata_ff, rsp_tdata_in;

   logic                          req_fire;
   logic                          csr_write;
   logic [PTR_W-1:0]              next_ptr;
   logic                          ram_rd_en;
   logic [rbwa_pkg::SAMPLE_W-1:0] ram_rd_data;
   logic [WIN_W:0]                trial;
   logic [WIN_W:0]                diff;
   logic [WIN_W-1:0]              clamped;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign next_ptr   = (ptr_ff == LAST_PTR) ? '0 : ptr_ff + 1'b1;
   assign ram_rd_en  = (state_ff == ST_SUM) && (left_ff != '0);

   assign csr_prdata =
      (csr_paddr[rbwa_pkg::CSR_ADDR_W-1:2] == rbwa_pkg::REG_WINDOW_LENGTH) ?
      {{(rbwa_pkg::CSR_DATA_W-WIN_W){1'b0}}, window_ff} : '0;

   always_comb begin
      if (window_ff == '0) begin
         clamped = WIN_W'(1);
      end else if (window_ff > DEPTH_WIN) begin
         clamped = DEPTH_WIN;
      end else begin
         clamped = window_ff;
      end
   end

   // one restoring divide step: bring in the next dividend bit
   assign trial = {rem_ff, dv_ff[MEAN_W-1]};
   assign diff  = trial - {1'b0, win_ff};

   rbwa_ram #(
      .WIDTH (rbwa_pkg::SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (next_ptr),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      ptr_in        = ptr_ff;
      window_in     = window_ff;
      win_in        = win_ff;
      left_in       = left_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = 1'b0;
      vld_d_in      = vld_d_ff;
      sum_in        = sum_ff;
      rem_in        = rem_ff;
      dv_in         = dv_ff;
      step_in       = step_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_write &&
          csr_paddr[rbwa_pkg::CSR_ADDR_W-1:2] == rbwa_pkg::REG_WINDOW_LENGTH) begin
         window_in = csr_pwdata[WIN_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ptr_in             = next_ptr;
               valid_in[next_ptr] = 1'b1;
               win_in             = clamped;
               left_in            = clamped;
               rd_idx_in          = next_ptr;
               sum_in             = '0;
               state_in           = ST_SUM;
            end
         end
         ST_SUM: begin
            if (left_ff != '0) begin
               left_in   = left_ff - 1'b1;
               rd_idx_in = (rd_idx_ff == '0) ? LAST_PTR : rd_idx_ff - 1'b1;
               pend_in   = 1'b1;
               vld_d_in  = valid_ff[rd_idx_ff];
            end
            if (pend_ff) begin
               // never-written entries count as zero
               sum_in = sum_ff + (vld_d_ff ? SUM_W'(ram_rd_data) : '0);
            end
            if (left_ff == '0 && !pend_ff) begin
               // the top dividend bits stay below the window, so preload them
               rem_in   = sum_ff[SUM_W-1 -: WIN_W];
               dv_in    = {sum_ff[SUM_W-WIN_W-1:0], {rbwa_pkg::FRAC_W{1'b0}}};
               step_in  = STEP_W'(MEAN_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!diff[WIN_W]) begin
               rem_in = diff[WIN_W-1:0];
               dv_in  = {dv_ff[MEAN_W-2:0], 1'b1};
            end else begin
               rem_in = trial[WIN_W-1:0];
               dv_in  = {dv_ff[MEAN_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = dv_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         ptr_ff        <= '0;
         window_ff     <= rbwa_pkg::WINDOW_RESET;
         left_ff       <= '0;
         pend_ff       <= 1'b0;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         ptr_ff        <= ptr_in;
         window_ff     <= window_in;
         left_ff       <= left_in;
         pend_ff       <= pend_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      win_ff       <= win_in;
      rd_idx_ff    <= rd_idx_in;
      vld_d_ff     <= vld_d_in;
      sum_ff       <= sum_in;
      rem_ff       <= rem_in;
      dv_ff        <= dv_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

`ifndef SYNTHESIS
   a_pend_in_sum: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_SUM)
      else $error("read data returned outside the summing phase");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < win_ff)
      else $error("divide remainder not below the window");

   a_left_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> left_ff <= win_ff)
      else $error("read count exceeds the window");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready && state_ff == ST_SUM)
      else $error("new sample taken while one is in progress");
`endif

endmodule
